// ----- hdl/assert_macros.svh -----
// assertion macros shared by the rtl files
// no dependencies; define NO_ASSERTIONS to compile them out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// antecedent implies consequent in the same cycle
`define DBS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("implication check failed");
// antecedent implies consequent in the next cycle
`define DBS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("next-cycle check failed");
// condition holds in every cycle
`define DBS_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
	else $error("invariant check failed");
`else
`define DBS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define DBS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`define DBS_ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`endif
`endif

// ----- hdl/dbs_pkg.sv -----
// shared constants for the dbscan clustering block
// no dependencies
package dbs_pkg;
	localparam int MAX_POINTS_DEF = 1024;
	localparam int COORD_W = 18;
	localparam int POINT_W = 3 * COORD_W;
	localparam int EPS_W = 38;
	localparam int MINP_W = 11;
	localparam int CFG_W = 38;
	localparam int CFG_IDX_W = 1;
	localparam int IDX_W = 10;
	localparam int CID_W = 10;
	localparam int CNT_W = 11;
	localparam int SQ_W = 2 * COORD_W;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_EPS_SQ = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_POINTS = 1'd1;

	localparam logic [EPS_W-1:0] EPS_RESET = '0;
	localparam logic [MINP_W-1:0] MINP_RESET = 11'd4;

	// operation codes
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_READ = 1'b1;
endpackage

// ----- hdl/dbs_ram.sv -----
// generic single write port ram with registered read
// no dependencies
module dbs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read, held while idle
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

// ----- hdl/dbs_dist.sv -----
// shared squared-distance unit: one squarer used for the three axes, then compare
// depends on dbs_pkg
module dbs_dist
	import dbs_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [POINT_W-1:0] p_pt,
	input  logic [POINT_W-1:0] q_pt,
	input  logic [EPS_W-1:0]   eps_sq,
	output logic               done,
	output logic               near
);
	localparam logic [2:0] PH_IDLE = 3'd0;
	localparam logic [2:0] PH_A = 3'd1;
	localparam logic [2:0] PH_B = 3'd2;
	localparam logic [2:0] PH_C = 3'd3;
	localparam logic [2:0] PH_ACC = 3'd4;
	localparam logic [2:0] PH_CMP = 3'd5;

	logic [2:0]         ph_q;
	logic [POINT_W-1:0] q_q;
	logic [SQ_W-1:0]    sq_q;
	logic [EPS_W-1:0]   acc_q;
	logic [COORD_W-1:0] pc, qc;
	logic [COORD_W:0]   diff, absd;
	logic [COORD_W-1:0] mag;

	// phase counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= PH_IDLE;
		end else begin
			case (ph_q)
				PH_IDLE: ph_q <= start ? PH_A : PH_IDLE;
				PH_CMP:  ph_q <= PH_IDLE;
				default: ph_q <= ph_q + 3'd1;
			endcase
		end
	end

	// axis select
	always_comb begin
		case (ph_q)
			PH_A: begin
				pc = p_pt[3*COORD_W-1:2*COORD_W];
				qc = q_q[3*COORD_W-1:2*COORD_W];
			end
			PH_B: begin
				pc = p_pt[2*COORD_W-1:COORD_W];
				qc = q_q[2*COORD_W-1:COORD_W];
			end
			default: begin
				pc = p_pt[COORD_W-1:0];
				qc = q_q[COORD_W-1:0];
			end
		endcase
	end

	// absolute difference, fits in the coordinate width
	assign diff = {pc[COORD_W-1], pc} - {qc[COORD_W-1], qc};
	assign absd = diff[COORD_W] ? (~diff + 1'b1) : diff;
	assign mag = absd[COORD_W-1:0];

	// squarer and accumulator
	always_ff @(posedge clk) begin
		if (start && ph_q == PH_IDLE) begin
			q_q <= q_pt;
		end
		sq_q <= mag * mag;
		case (ph_q)
			PH_B:    acc_q <= {{(EPS_W-SQ_W){1'b0}}, sq_q};
			PH_C:    acc_q <= acc_q + {{(EPS_W-SQ_W){1'b0}}, sq_q};
			PH_ACC:  acc_q <= acc_q + {{(EPS_W-SQ_W){1'b0}}, sq_q};
			default: acc_q <= acc_q;
		endcase
	end

	assign done = (ph_q == PH_CMP);
	assign near = (acc_q <= eps_sq);
endmodule

// ----- hdl/dbscan_clustering.sv -----
// A point load that does not close a set has its status word come out on the next
// cycle; a label read passes through the registered read of the label ram and the
// ST_RDW state before its status word comes out. The load that closes a set starts
// the clustering pass, gets its status word when the pass ends, and the block stays
// busy until then: a sweep marks every label unseen, then every neighbour search walks
// all stored points through the shared squarer, once to count and once more to queue
// seeds for each core point. After reset the block is busy while it clears the queued
// marks. Results appear for one cycle with done high and cannot be stalled.
// Configuration is written through cfg_we while idle; that is up to the user, as the block has no check for it.
// depends on dbs_pkg, dbs_ram, dbs_dist and assert_macros.svh
`include "assert_macros.svh"
module dbscan_clustering
	import dbs_pkg::*;
#(
	parameter int MAX_POINTS = MAX_POINTS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	output logic                 done,
	input  logic                 operation,
	input  logic [COORD_W-1:0]   coord_a,
	input  logic [COORD_W-1:0]   coord_b,
	input  logic [COORD_W-1:0]   coord_c,
	input  logic                 final_point,
	input  logic [IDX_W-1:0]     point_index,
	output logic [CID_W-1:0]     cluster_label,
	output logic                 is_noise,
	output logic [CNT_W-1:0]     cluster_count,
	output logic [CNT_W-1:0]     point_total,
	output logic                 overflow,
	output logic                 bad_index,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);
	localparam int IW = $clog2(MAX_POINTS);
	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam int LW = IW + 2;
	localparam int MW = (CW > MINP_W) ? CW : MINP_W;
	localparam int XW = (CW > IDX_W) ? CW : IDX_W;

	// sequencer states
	localparam logic [4:0] ST_CLR = 5'd0;
	localparam logic [4:0] ST_IDLE = 5'd1;
	localparam logic [4:0] ST_RDW = 5'd2;
	localparam logic [4:0] ST_LINIT = 5'd3;
	localparam logic [4:0] ST_OUTER = 5'd4;
	localparam logic [4:0] ST_OCHK = 5'd5;
	localparam logic [4:0] ST_PRD = 5'd6;
	localparam logic [4:0] ST_PLD = 5'd7;
	localparam logic [4:0] ST_JRD = 5'd8;
	localparam logic [4:0] ST_JGO = 5'd9;
	localparam logic [4:0] ST_DIST = 5'd10;
	localparam logic [4:0] ST_SEND = 5'd11;
	localparam logic [4:0] ST_POP = 5'd12;
	localparam logic [4:0] ST_QGET = 5'd13;
	localparam logic [4:0] ST_QLBL = 5'd14;
	localparam logic [4:0] ST_QCLR = 5'd15;
	localparam logic [4:0] ST_QCLW = 5'd16;

	// scan modes
	localparam logic [1:0] M_CNT_I = 2'd0;
	localparam logic [1:0] M_CNT_Q = 2'd1;
	localparam logic [1:0] M_ENQ = 2'd2;

	localparam logic [LW-1:0] L_UNSEEN = {2'b10, {IW{1'b0}}};
	localparam logic [LW-1:0] L_NOISE = {2'b01, {IW{1'b0}}};

	logic [4:0]         st_q;
	logic [1:0]         mode_q;
	logic [EPS_W-1:0]   eps_q;
	logic [MINP_W-1:0]  minp_q;
	logic [CW-1:0]      loaded_q, clusters_q, cid_q;
	logic [CW-1:0]      i_q, j_q, k_q, cnt_q, head_q, tail_q;
	logic [IW-1:0]      p_q;
	logic               dropped_q, closed_q, done_q;
	logic [CID_W-1:0]   id_q;
	logic               noise_q, bad_q;
	logic [POINT_W-1:0] p_pt_q;

	logic               acc_ld, acc_rd, full, is_core, enq_ok, read_bad;
	logic [CW-1:0]      eff_cnt;
	logic               pt_we, pt_re, lbl_we, lbl_re, mk_we, mk_re, mk_wd, q_we, q_re;
	logic [IW-1:0]      pt_ra, lbl_wa, lbl_ra, mk_wa, q_ra;
	logic [LW-1:0]      lbl_wd, lbl_rd;
	logic [POINT_W-1:0] pt_rd;
	logic               mk_rd;
	logic [IW-1:0]      q_rd;
	logic               d_start, d_done, d_near;

	// handshake decode
	assign acc_ld = start && (st_q == ST_IDLE) && (operation == OP_LOAD);
	assign acc_rd = start && (st_q == ST_IDLE) && (operation == OP_READ);
	assign eff_cnt = closed_q ? '0 : loaded_q;
	assign full = (eff_cnt >= CW'(MAX_POINTS));
	assign is_core = (MW'(cnt_q) >= MW'(minp_q));
	assign read_bad = (XW'(point_index) >= XW'(loaded_q))
		|| (XW'(point_index) >= XW'(MAX_POINTS));
	assign enq_ok = (mode_q == M_ENQ) && d_near && !mk_rd && (lbl_rd[IW+1] || lbl_rd[IW]);
	assign d_start = (st_q == ST_JGO);

	// memory port control
	always_comb begin
		pt_we = acc_ld && !full;
		pt_re = (st_q == ST_PRD) || ((st_q == ST_JRD) && (j_q != loaded_q));
		pt_ra = (st_q == ST_PRD) ? p_q : j_q[IW-1:0];

		lbl_re = 1'b0;
		lbl_ra = j_q[IW-1:0];
		lbl_we = 1'b0;
		lbl_wa = p_q;
		lbl_wd = {2'b00, cid_q[IW-1:0]};
		mk_re = (st_q == ST_JRD) && (j_q != loaded_q);
		mk_we = 1'b0;
		mk_wa = j_q[IW-1:0];
		mk_wd = 1'b0;
		q_we = (st_q == ST_DIST) && d_done && enq_ok;
		q_re = 1'b0;
		q_ra = head_q[IW-1:0];
		case (st_q)
			ST_IDLE: begin
				lbl_re = acc_rd;
				lbl_ra = IW'(point_index);
			end
			ST_CLR: begin
				mk_we = 1'b1;
				mk_wa = k_q[IW-1:0];
			end
			ST_LINIT: begin
				lbl_we = (k_q != loaded_q);
				lbl_wa = k_q[IW-1:0];
				lbl_wd = L_UNSEEN;
			end
			ST_OUTER: begin
				lbl_re = (i_q != loaded_q);
				lbl_ra = i_q[IW-1:0];
			end
			ST_JRD: begin
				lbl_re = (j_q != loaded_q);
			end
			ST_DIST: begin
				mk_we = d_done && enq_ok;
				mk_wd = 1'b1;
			end
			ST_SEND: begin
				lbl_we = (mode_q == M_CNT_I);
				lbl_wd = is_core ? {2'b00, cid_q[IW-1:0]} : L_NOISE;
			end
			ST_POP: begin
				q_re = (head_q != tail_q);
			end
			ST_QGET: begin
				lbl_re = 1'b1;
				lbl_ra = q_rd;
			end
			ST_QLBL: begin
				lbl_we = lbl_rd[IW+1] || lbl_rd[IW];
			end
			ST_QCLR: begin
				q_re = (k_q != tail_q);
				q_ra = k_q[IW-1:0];
			end
			ST_QCLW: begin
				mk_we = 1'b1;
				mk_wa = q_rd;
			end
			default: begin
				lbl_re = 1'b0;
			end
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= EPS_RESET;
			minp_q <= MINP_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_EPS_SQ:     eps_q <= cfg_data[EPS_W-1:0];
				REG_MIN_POINTS: minp_q <= cfg_data[MINP_W-1:0];
				default:        eps_q <= eps_q;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_CLR;
			mode_q <= M_CNT_I;
			loaded_q <= '0;
			clusters_q <= '0;
			cid_q <= '0;
			i_q <= '0;
			j_q <= '0;
			k_q <= '0;
			cnt_q <= '0;
			head_q <= '0;
			tail_q <= '0;
			p_q <= '0;
			dropped_q <= 1'b0;
			closed_q <= 1'b0;
			done_q <= 1'b0;
			id_q <= '0;
			noise_q <= 1'b0;
			bad_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (st_q)
				ST_CLR: begin
					k_q <= k_q + 1'b1;
					if (k_q == CW'(MAX_POINTS - 1)) begin
						st_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (acc_ld) begin
						id_q <= '0;
						noise_q <= 1'b0;
						bad_q <= 1'b0;
						closed_q <= 1'b0;
						if (full) begin
							loaded_q <= eff_cnt;
							dropped_q <= 1'b1;
						end else begin
							loaded_q <= eff_cnt + 1'b1;
							dropped_q <= closed_q ? 1'b0 : dropped_q;
						end
						if (final_point) begin
							k_q <= '0;
							st_q <= ST_LINIT;
						end else begin
							done_q <= 1'b1;
						end
					end else if (acc_rd) begin
						bad_q <= read_bad;
						st_q <= ST_RDW;
					end
				end
				ST_RDW: begin
					noise_q <= !bad_q && lbl_rd[IW];
					id_q <= (bad_q || lbl_rd[IW] || lbl_rd[IW+1]) ? '0
						: CID_W'(lbl_rd[IW-1:0]);
					done_q <= 1'b1;
					st_q <= ST_IDLE;
				end
				ST_LINIT: begin
					if (k_q == loaded_q) begin
						i_q <= '0;
						cid_q <= '0;
						head_q <= '0;
						tail_q <= '0;
						st_q <= ST_OUTER;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				ST_OUTER: begin
					if (i_q == loaded_q) begin
						clusters_q <= cid_q;
						closed_q <= 1'b1;
						done_q <= 1'b1;
						st_q <= ST_IDLE;
					end else begin
						st_q <= ST_OCHK;
					end
				end
				ST_OCHK: begin
					if (lbl_rd[IW+1]) begin
						p_q <= i_q[IW-1:0];
						mode_q <= M_CNT_I;
						st_q <= ST_PRD;
					end else begin
						i_q <= i_q + 1'b1;
						st_q <= ST_OUTER;
					end
				end
				ST_PRD: begin
					st_q <= ST_PLD;
				end
				ST_PLD: begin
					j_q <= '0;
					cnt_q <= '0;
					st_q <= ST_JRD;
				end
				ST_JRD: begin
					st_q <= (j_q == loaded_q) ? ST_SEND : ST_JGO;
				end
				ST_JGO: begin
					st_q <= ST_DIST;
				end
				ST_DIST: begin
					if (d_done) begin
						if (d_near && mode_q != M_ENQ) begin
							cnt_q <= cnt_q + 1'b1;
						end
						if (enq_ok) begin
							tail_q <= tail_q + 1'b1;
						end
						j_q <= j_q + 1'b1;
						st_q <= ST_JRD;
					end
				end
				ST_SEND: begin
					j_q <= '0;
					case (mode_q)
						M_CNT_I: begin
							if (is_core) begin
								mode_q <= M_ENQ;
								st_q <= ST_JRD;
							end else begin
								i_q <= i_q + 1'b1;
								st_q <= ST_OUTER;
							end
						end
						M_CNT_Q: begin
							if (is_core) begin
								mode_q <= M_ENQ;
								st_q <= ST_JRD;
							end else begin
								st_q <= ST_POP;
							end
						end
						default: st_q <= ST_POP;
					endcase
				end
				ST_POP: begin
					if (head_q == tail_q) begin
						k_q <= '0;
						st_q <= ST_QCLR;
					end else begin
						head_q <= head_q + 1'b1;
						st_q <= ST_QGET;
					end
				end
				ST_QGET: begin
					p_q <= q_rd;
					st_q <= ST_QLBL;
				end
				ST_QLBL: begin
					if (lbl_rd[IW+1]) begin
						mode_q <= M_CNT_Q;
						st_q <= ST_PRD;
					end else begin
						st_q <= ST_POP;
					end
				end
				ST_QCLR: begin
					if (k_q == tail_q) begin
						cid_q <= cid_q + 1'b1;
						i_q <= i_q + 1'b1;
						head_q <= '0;
						tail_q <= '0;
						st_q <= ST_OUTER;
					end else begin
						st_q <= ST_QCLW;
					end
				end
				ST_QCLW: begin
					k_q <= k_q + 1'b1;
					st_q <= ST_QCLR;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// coordinates of the point whose neighbours are searched
	always_ff @(posedge clk) begin
		if (st_q == ST_PLD) begin
			p_pt_q <= pt_rd;
		end
	end

	dbs_ram #(.WIDTH(POINT_W), .DEPTH(MAX_POINTS)) u_pt_ram (
		.clk(clk), .we(pt_we), .waddr(eff_cnt[IW-1:0]), .wdata({coord_a, coord_b, coord_c}),
		.re(pt_re), .raddr(pt_ra), .rdata(pt_rd)
	);

	dbs_ram #(.WIDTH(LW), .DEPTH(MAX_POINTS)) u_lbl_ram (
		.clk(clk), .we(lbl_we), .waddr(lbl_wa), .wdata(lbl_wd),
		.re(lbl_re), .raddr(lbl_ra), .rdata(lbl_rd)
	);

	dbs_ram #(.WIDTH(1), .DEPTH(MAX_POINTS)) u_mark_ram (
		.clk(clk), .we(mk_we), .waddr(mk_wa), .wdata(mk_wd),
		.re(mk_re), .raddr(j_q[IW-1:0]), .rdata(mk_rd)
	);

	dbs_ram #(.WIDTH(IW), .DEPTH(MAX_POINTS)) u_queue_ram (
		.clk(clk), .we(q_we), .waddr(tail_q[IW-1:0]), .wdata(j_q[IW-1:0]),
		.re(q_re), .raddr(q_ra), .rdata(q_rd)
	);

	dbs_dist u_dist (
		.clk(clk), .arst_n(arst_n), .start(d_start), .p_pt(p_pt_q), .q_pt(pt_rd),
		.eps_sq(eps_q), .done(d_done), .near(d_near)
	);

	// result word
	assign busy = (st_q != ST_IDLE);
	assign done = done_q;
	assign cluster_label = id_q;
	assign is_noise = noise_q;
	assign bad_index = bad_q;
	assign cluster_count = CNT_W'(clusters_q);
	assign point_total = CNT_W'(loaded_q);
	assign overflow = dropped_q;

	// checks
	`DBS_ASSERT_NEXT(a_read_busy, clk, arst_n, acc_rd, busy && !done)
	`DBS_ASSERT_IMP(a_bad_clean, clk, arst_n, done && bad_index, !is_noise && cluster_label == '0)
	`DBS_ASSERT_ALWAYS(a_queue_order, clk, arst_n, head_q <= tail_q)
	`DBS_ASSERT_ALWAYS(a_count_cap, clk, arst_n, loaded_q <= CW'(MAX_POINTS))
endmodule

// ----- tb/sv/dbscan_clustering_test.sv -----
// self-checking testbench for dbscan_clustering: point loads, clustering runs, label reads
// predicts every result word with its own dbscan model and checks it field by field
// depends on dbs_pkg and the dbscan_clustering rtl
module dbscan_clustering_test;
	import dbs_pkg::*;

	localparam int CAP = MAX_POINTS_DEF;
	localparam int CYCLE_LIMIT = 3000000;
	localparam int LBL_NOISE = -1;
	localparam int LBL_UNSEEN = -2;
	localparam int LBL_UNDEF = -3;

	typedef struct {
		logic [CID_W-1:0] cid;
		logic             noise;
		logic [CNT_W-1:0] ccount;
		logic [CNT_W-1:0] ptotal;
		logic             ovf;
		logic             bad;
	} status_word_t;

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy, done;
	logic operation = OP_LOAD;
	logic [COORD_W-1:0] coord_a = '0, coord_b = '0, coord_c = '0;
	logic final_point = 0;
	logic [IDX_W-1:0] point_index = '0;
	logic [CID_W-1:0] cluster_label;
	logic is_noise;
	logic [CNT_W-1:0] cluster_count, point_total;
	logic overflow, bad_index;
	logic cfg_we = 0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_EPS_SQ;
	logic [CFG_W-1:0] cfg_data = '0;

	dbscan_clustering DUT (.*);

	always #6 clk = ~clk;

	// model state
	int pa[CAP], pb[CAP], pc[CAP];
	int labels[CAP];
	bit queued[CAP];
	int seeds[CAP];
	int nbr[CAP];
	int loaded_n, clusters_n, defined_n;
	bit dropped, closed;
	longint eps_m;
	int minp_m;

	status_word_t pending_words[$];
	int errors = 0;
	int cycles = 0;
	int idle_pct = 0;

	// coordinate as the port sees it: low bits, sign extended
	function automatic int sext_coord(int v);
		logic signed [COORD_W-1:0] s;
		s = v[COORD_W-1:0];
		return int'(s);
	endfunction

	// exact neighbour search, self included
	function automatic int find_nbrs(int p);
		int cnt;
		longint d, da, db, dc;
		cnt = 0;
		for (int j = 0; j < loaded_n; j++) begin
			da = pa[p] - pa[j];
			db = pb[p] - pb[j];
			dc = pc[p] - pc[j];
			d = da * da + db * db + dc * dc;
			if (d <= eps_m) begin
				nbr[cnt] = j;
				cnt++;
			end
		end
		return cnt;
	endfunction

	// breadth-first cluster growth in load order
	function automatic void cluster_set();
		int cid, head, tail, cnt, q, qc, nb;
		cid = 0;
		for (int i = 0; i < loaded_n; i++) labels[i] = LBL_UNSEEN;
		if (loaded_n > defined_n) defined_n = loaded_n;
		for (int i = 0; i < loaded_n; i++) begin
			if (labels[i] != LBL_UNSEEN) continue;
			cnt = find_nbrs(i);
			if (cnt < minp_m) begin
				labels[i] = LBL_NOISE;
				continue;
			end
			labels[i] = cid;
			head = 0;
			tail = 0;
			for (int j = 0; j < cnt; j++) begin
				nb = nbr[j];
				if (nb != i && !queued[nb] && tail < CAP) begin
					seeds[tail] = nb;
					tail++;
					queued[nb] = 1;
				end
			end
			while (head < tail) begin
				q = seeds[head];
				head++;
				// noise reached later becomes a border point
				if (labels[q] == LBL_NOISE) labels[q] = cid;
				if (labels[q] != LBL_UNSEEN) continue;
				labels[q] = cid;
				qc = find_nbrs(q);
				if (qc >= minp_m) begin
					for (int j = 0; j < qc; j++) begin
						nb = nbr[j];
						if (!queued[nb] && tail < CAP &&
						    (labels[nb] == LBL_UNSEEN || labels[nb] == LBL_NOISE)) begin
							seeds[tail] = nb;
							tail++;
							queued[nb] = 1;
						end
					end
				end
			end
			for (int j = 0; j < tail; j++) queued[seeds[j]] = 0;
			cid++;
		end
		clusters_n = cid;
	endfunction

	// expected status word for one accepted item
	function automatic status_word_t predict_word(logic op, int a, int b, int c, logic fin,
	                                              int idx);
		status_word_t w;
		w.cid = '0;
		w.noise = 0;
		w.bad = 0;
		if (op == OP_LOAD) begin
			if (closed) begin
				loaded_n = 0;
				dropped = 0;
				closed = 0;
			end
			if (loaded_n < CAP) begin
				pa[loaded_n] = sext_coord(a);
				pb[loaded_n] = sext_coord(b);
				pc[loaded_n] = sext_coord(c);
				loaded_n++;
			end else
				dropped = 1;
			if (fin) begin
				cluster_set();
				closed = 1;
			end
		end else begin
			if (idx >= loaded_n) w.bad = 1;
			else if (labels[idx] == LBL_NOISE) w.noise = 1;
			else w.cid = labels[idx][CID_W-1:0];
		end
		w.ccount = clusters_n[CNT_W-1:0];
		w.ptotal = loaded_n[CNT_W-1:0];
		w.ovf = dropped;
		return w;
	endfunction

	// send one word and wait for acceptance; start stays high afterwards unless a random sender gap follows
	task automatic send_word(logic op, int a, int b, int c, logic fin, int idx);
		operation <= op;
		coord_a <= a[COORD_W-1:0];
		coord_b <= b[COORD_W-1:0];
		coord_c <= c[COORD_W-1:0];
		final_point <= fin;
		point_index <= idx[IDX_W-1:0];
		start <= 1;
		do @(posedge clk); while (busy);
		pending_words.push_back(predict_word(op, a, b, c, fin, idx));
		// random sender gap
		if ($urandom_range(99) < idle_pct) begin
			start <= 0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
	endtask

	task automatic load_point(int a, int b, int c, logic fin);
		send_word(OP_LOAD, a, b, c, fin, 0);
	endtask

	// read a label; skips indexes whose label was never written
	task automatic read_label(int idx);
		if (idx < loaded_n && idx >= defined_n) return;
		send_word(OP_READ, $urandom, $urandom, $urandom, $urandom_range(1), idx);
	endtask

	// pick a read index: mostly valid, sometimes out of range
	function automatic int pick_index();
		int lim;
		lim = (loaded_n < defined_n) ? loaded_n : defined_n;
		if ((lim == 0 || $urandom_range(99) < 20) && loaded_n < CAP)
			return $urandom_range(CAP - 1, loaded_n);
		if (lim == 0) return 0;
		return $urandom_range(lim - 1);
	endfunction

	// wait until every expected word has come and the block is idle
	task automatic drain();
		start <= 0;
		while (pending_words.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		drain();
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
		if (idx == REG_EPS_SQ) eps_m = val;
		else minp_m = val[MINP_W-1:0];
	endtask

	task automatic set_params(longint e, int m);
		write_reg(REG_EPS_SQ, e[CFG_W-1:0]);
		write_reg(REG_MIN_POINTS, m[CFG_W-1:0]);
	endtask

	// status of an empty block, default registers
	task automatic test_empty();
		read_label(0);
		read_label(CAP - 1);
		load_point(0, 0, 0, 0);
		read_label(0);
		load_point(0, 0, 1, 1);
	endtask

	// coordinate extremes with tight and wide radius
	task automatic test_extremes();
		set_params(0, 1);
		load_point(-131072, 131071, -131072, 0);
		load_point(131071, -131072, 131071, 0);
		load_point(131071, -131072, 131071, 1);
		read_label(0);
		read_label(2);
		read_label(3);
		set_params((longint'(1) << 38) - 1, 1024);
		load_point(-131072, -131072, -131072, 0);
		load_point(131071, 131071, 131071, 1);
		read_label(1);
		set_params(0, 0);
		load_point(5, 5, 5, 1);
		read_label(0);
	endtask

	// noise seen first becomes border of a later cluster; read before the run
	task automatic test_border();
		set_params(100, 3);
		load_point(0, 0, 0, 0);
		read_label(0);
		load_point(10, 0, 0, 0);
		load_point(20, 0, 0, 0);
		load_point(20, 1, 0, 0);
		load_point(500, 0, 0, 1);
		for (int i = 0; i < 6; i++) read_label(i);
	endtask

	// random sets of small clustered groups plus stray points
	task automatic test_random(int n_items);
		int sent, set_n, ca, cb, cc, r, off;
		sent = 0;
		while (sent < n_items) begin
			case ($urandom_range(9))
				0: set_params(0, $urandom_range(2));
				1: set_params({$urandom, $urandom}, $urandom_range(1024));
				default: set_params($urandom_range(60000), $urandom_range(5));
			endcase
			set_n = $urandom_range(12, 1);
			ca = $urandom_range(262143) - 131072;
			cb = $urandom_range(262143) - 131072;
			cc = $urandom_range(262143) - 131072;
			off = (2 ** $urandom_range(8)) - 1;
			for (int i = 0; i < set_n; i++) begin
				if ($urandom_range(5) == 0) begin
					ca = $urandom_range(262143) - 131072;
					cb = $urandom_range(262143) - 131072;
					cc = $urandom_range(262143) - 131072;
				end
				r = ca + $urandom_range(2 * off) - off;
				load_point(r, cb + $urandom_range(2 * off) - off,
				           cc + $urandom_range(2 * off) - off, i == set_n - 1);
				sent++;
				if ($urandom_range(5) == 0) begin
					read_label(pick_index());
					sent++;
				end
			end
			repeat ($urandom_range(set_n + 2)) begin
				read_label(pick_index());
				sent++;
			end
		end
	endtask

	// sender holds off until everything has come back
	task automatic test_drain_pause();
		drain();
		read_label(0);
		read_label(loaded_n);
	endtask

	// fill to capacity and beyond; the set stays open
	task automatic test_overflow();
		idle_pct = 0;
		set_params(1000, 2);
		for (int i = 0; i <= CAP; i++)
			load_point($urandom_range(262143) - 131072, i, -i, 0);
		for (int i = 0; i < 5; i++) read_label(pick_index());
		load_point(1, 2, 3, 0);
	endtask

	// result checker
	always @(posedge clk) begin
		status_word_t w;
		if (arst_n && done) begin
			if (pending_words.size() == 0) begin
				$error("status word with none expected");
				errors++;
			end else begin
				w = pending_words.pop_front();
				if (cluster_label !== w.cid) begin
					$error("cluster_label expected %0d got %0d", w.cid, cluster_label);
					errors++;
				end
				if (is_noise !== w.noise) begin
					$error("is_noise expected %0d got %0d", w.noise, is_noise);
					errors++;
				end
				if (cluster_count !== w.ccount) begin
					$error("cluster_count expected %0d got %0d", w.ccount, cluster_count);
					errors++;
				end
				if (point_total !== w.ptotal) begin
					$error("point_total expected %0d got %0d", w.ptotal, point_total);
					errors++;
				end
				if (overflow !== w.ovf) begin
					$error("overflow expected %0d got %0d", w.ovf, overflow);
					errors++;
				end
				if (bad_index !== w.bad) begin
					$error("bad_index expected %0d got %0d", w.bad, bad_index);
					errors++;
				end
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < CAP; i++) begin
			labels[i] = LBL_UNDEF;
			queued[i] = 0;
		end
		loaded_n = 0;
		clusters_n = 0;
		defined_n = 0;
		dropped = 0;
		closed = 0;
		eps_m = EPS_RESET;
		minp_m = MINP_RESET;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_empty();
		test_extremes();
		test_border();
		idle_pct = 0;
		test_random(25);
		idle_pct = 65;
		test_random(25);
		test_drain_pause();
		idle_pct = 0;
		test_random(15);
		idle_pct = 13;
		test_random(25);
		test_overflow();
		drain();
		repeat (20) @(posedge clk);
		if (errors == 0 && pending_words.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule

// ----- files.f -----
+incdir+hdl
hdl/dbs_pkg.sv
hdl/dbs_ram.sv
hdl/dbs_dist.sv
hdl/dbscan_clustering.sv
tb/sv/dbscan_clustering_test.sv
